// ----- hw/rtl/assert_macros.svh -----
// shared assertion macros for the rtl folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ADMS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// antecedent now, consequent on the next clock edge
`define ADMS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/adms_pkg.sv -----
`default_nettype none

package adms_pkg;

   // field widths
   localparam int AXIS_W   = 17;
   localparam int MAG_W    = 17;
   localparam int SUM_W    = 34;
   localparam int AVG_W    = 25;
   localparam int LEVEL_W  = 9;
   localparam int GRAV_W   = 16;
   localparam int WEIGHT_W = 16;

   // shared multiplier operand and product widths
   localparam int MUL_A_W = 17;
   localparam int MUL_B_W = 25;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = WEIGHT_W + MUL_B_W;

   // square root iterations, two bits of the radicand each
   localparam int ROOT_STEPS = SUM_W / 2;

   // register port
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   // register reset values
   localparam logic                ENABLE_RESET  = 1'b0;
   localparam logic [GRAV_W-1:0]   GRAVITY_RESET = 16'd2510;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET  = 16'd6554;

   // register indexes
   typedef enum logic [1:0] {
      REG_ENABLE  = 2'd0,
      REG_GRAVITY = 2'd1,
      REG_WEIGHT  = 2'd2
   } reg_index_type;

endpackage

`default_nettype wire

// ----- hw/rtl/adms_req_if.sv -----
`default_nettype none

interface adms_req_if;
   import adms_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [AXIS_W-1:0] accel_x;
   logic signed [AXIS_W-1:0] accel_y;
   logic signed [AXIS_W-1:0] accel_z;

   modport source (output valid, output accel_x, output accel_y, output accel_z,
                   input ready);
   modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                   output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/adms_rsp_if.sv -----
`default_nettype none

interface adms_rsp_if;
   import adms_pkg::*;

   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] smoothed_level;

   modport source (output valid, output smoothed_level, input ready);
   modport sink   (input valid, input smoothed_level, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/accel_dynamic_magnitude_smoother.sv -----
// Smoothed dynamic acceleration level.
// req_chan carries one signed Q8.8 three-axis sample per transaction; rsp_chan
// returns one 9-bit smoothed level, whole m/s^2, per accepted sample, in order.
// Both channels move a transaction when valid and ready are high at a clock edge.
// The csr_ port holds enable, gravity offset (Q8.8) and weight (Q0.16); write
// it only while no sample is in flight.
// Steps from acceptance to rsp valid when enabled: 3 squares and a sum on
// the shared multiplier, 17 square root steps, one difference, two products
// on the same multiplier, one update add and the output step; when disabled
// the sample goes straight to the output step. A new sample is taken once
// the block is back in idle, so the block cannot take a new sample before it
// is through with the last one.
// The result sits in an output register; the next sample is accepted while it
// waits. If the receiver still stalls when the next result is done, the block
// holds it and keeps req ready low until the output register frees.
// Synchronous reset clears the average, restores register defaults and drops
// the response valid and any sample in flight.
`default_nettype none
`include "assert_macros.svh"

module accel_dynamic_magnitude_smoother (
   input  logic                          clock,
   input  logic                          reset,
   adms_req_if.sink                      req_chan,
   adms_rsp_if.source                    rsp_chan,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [adms_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [adms_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [adms_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import adms_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SQUARE,
      S_ROOT,
      S_DIFF,
      S_MULW,
      S_MULA,
      S_ADD,
      S_FINISH
   } state_type;

   localparam logic [4:0] ROOT_LAST = 5'(ROOT_STEPS - 1);
   localparam logic [4:0] SQ_LAST   = 5'd3;

   // absolute value of a two's complement axis
   function automatic logic [AXIS_W-1:0] axis_abs(input logic [AXIS_W-1:0] v);
      return v[AXIS_W-1] ? (~v + AXIS_W'(1)) : v;
   endfunction

   state_type            state_ff, state_in;
   logic [4:0]           step_ff, step_in;
   logic [AXIS_W-1:0]    ax_ff [3];
   logic [AXIS_W-1:0]    ax_in [3];
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [SUM_W-1:0]     rem_ff, rem_in;
   logic [SUM_W-1:0]     root_ff, root_in;
   logic [MAG_W-1:0]     d_ff, d_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [AVG_W-1:0]     avg_ff, avg_in;
   logic                 zero_ff, zero_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]   rsp_level_ff, rsp_level_in;
   logic                 enable_ff, enable_in;
   logic [GRAV_W-1:0]    grav_ff, grav_in;
   logic [WEIGHT_W-1:0]  weight_ff, weight_in;

   logic                 req_accept;
   logic                 csr_write;
   reg_index_type        csr_index;
   logic [MUL_A_W-1:0]   mul_a;
   logic [MUL_B_W-1:0]   mul_b;
   logic [SUM_W-1:0]     bit_val;
   logic [SUM_W:0]       trial;
   logic [MAG_W-1:0]     mag;
   logic [PROD_W:0]      total;
   logic [AVG_W:0]       level_sum;

   // handshakes
   assign req_chan.ready       = (state_ff == S_IDLE);
   assign req_accept           = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.smoothed_level = rsp_level_ff;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      case (csr_index)
         REG_ENABLE:  csr_prdata = CSR_DW'(enable_ff);
         REG_GRAVITY: csr_prdata = CSR_DW'(grav_ff);
         REG_WEIGHT:  csr_prdata = CSR_DW'(weight_ff);
         default:     csr_prdata = '0;
      endcase
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_SQUARE: begin
            if (step_ff != SQ_LAST) begin
               mul_a = ax_ff[step_ff[1:0]];
               mul_b = MUL_B_W'(ax_ff[step_ff[1:0]]);
            end
         end
         S_MULW: begin
            mul_a = MUL_A_W'(weight_ff);
            mul_b = {d_ff, 8'd0};
         end
         S_MULA: begin
            mul_a = (MUL_A_W'(1) << WEIGHT_W) - MUL_A_W'(weight_ff);
            mul_b = avg_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   // square root step and datapath helpers
   assign bit_val   = SUM_W'(1) << {step_ff, 1'b0};
   assign trial     = (SUM_W + 1)'(root_ff) + (SUM_W + 1)'(bit_val);
   assign mag       = root_ff[MAG_W-1:0];
   assign total     = (PROD_W + 1)'(acc_ff) + (PROD_W + 1)'(prod_ff)
                      + (PROD_W + 1)'(32768);
   assign level_sum = (AVG_W + 1)'(avg_ff) + (AVG_W + 1)'(32768);

   // sequencer and next values
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      ax_in        = ax_ff;
      sum_in       = sum_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      d_in         = d_ff;
      acc_in       = acc_ff;
      avg_in       = avg_ff;
      zero_in      = zero_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_level_in = rsp_level_ff;
      enable_in    = enable_ff;
      grav_in      = grav_ff;
      weight_in    = weight_ff;

      // register writes
      if (csr_write) begin
         case (csr_index)
            REG_ENABLE:  enable_in = csr_pwdata[0];
            REG_GRAVITY: grav_in   = csr_pwdata[GRAV_W-1:0];
            REG_WEIGHT:  weight_in = csr_pwdata[WEIGHT_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               ax_in[0] = axis_abs(req_chan.accel_x);
               ax_in[1] = axis_abs(req_chan.accel_y);
               ax_in[2] = axis_abs(req_chan.accel_z);
               sum_in   = '0;
               step_in  = '0;
               zero_in  = !enable_ff;
               state_in = enable_ff ? S_SQUARE : S_FINISH;
            end
         end
         // squares go through the multiplier, each summed in the cycle after its product
         S_SQUARE: begin
            if (step_ff != '0) begin
               sum_in = sum_ff + prod_ff[SUM_W-1:0];
            end
            if (step_ff == SQ_LAST) begin
               rem_in   = sum_ff + prod_ff[SUM_W-1:0];
               root_in  = '0;
               step_in  = ROOT_LAST;
               state_in = S_ROOT;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         // one result bit per cycle
         S_ROOT: begin
            if ((SUM_W + 1)'(rem_ff) >= trial) begin
               rem_in  = rem_ff - trial[SUM_W-1:0];
               root_in = (root_ff >> 1) + bit_val;
            end else begin
               root_in = root_ff >> 1;
            end
            if (step_ff == '0) begin
               state_in = S_DIFF;
            end else begin
               step_in = step_ff - 5'd1;
            end
         end
         S_DIFF: begin
            if (mag >= MAG_W'(grav_ff)) begin
               d_in = mag - MAG_W'(grav_ff);
            end else begin
               d_in = MAG_W'(grav_ff) - mag;
            end
            state_in = S_MULW;
         end
         S_MULW: begin
            state_in = S_MULA;
         end
         S_MULA: begin
            acc_in   = prod_ff[ACC_W-1:0];
            state_in = S_ADD;
         end
         S_ADD: begin
            avg_in   = total[AVG_W+15:16];
            state_in = S_FINISH;
         end
         // wait for the output register to free
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = zero_ff ? '0 : level_sum[LEVEL_W+15:16];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      ax_ff        <= ax_in;
      step_ff      <= step_in;
      sum_ff       <= sum_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      d_ff         <= d_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      zero_ff      <= zero_in;
      rsp_level_ff <= rsp_level_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         avg_ff       <= '0;
         enable_ff    <= ENABLE_RESET;
         grav_ff      <= GRAVITY_RESET;
         weight_ff    <= WEIGHT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         avg_ff       <= avg_in;
         enable_ff    <= enable_in;
         grav_ff      <= grav_in;
         weight_ff    <= weight_in;
      end
   end

   // checks
   `ADMS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_accept,
      state_ff != S_IDLE, "block still idle after taking a sample")
   `ADMS_ASSERT_NEXT(a_avg_only_on_update, clock, reset, state_ff != S_ADD,
      $stable(avg_ff), "average changed outside the update step")
   `ADMS_ASSERT(a_root_residual, clock, reset,
      (state_ff == S_DIFF) |-> (rem_ff <= {root_ff[SUM_W-2:0], 1'b0}),
      "square root residual above twice the root")
   `ADMS_ASSERT(a_rsp_from_finish, clock, reset,
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FINISH),
      "result raised outside the finish step")

endmodule

`default_nettype wire

// ----- tb/adms_level_checker.sv -----
`timescale 1ns / 100ps

module adms_level_checker (
   input  logic                        clock,
   input  logic                        reset,
   adms_req_if                         req_mon,
   adms_rsp_if                         rsp_mon,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [adms_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [adms_pkg::CSR_DW-1:0] csr_pwdata,
   input  logic [adms_pkg::CSR_DW-1:0] csr_prdata,
   input  logic                        csr_pready,
   output int                          mismatch_count,
   output int                          pending_levels,
   output int                          levels_checked
);
   import adms_pkg::*;

   // shadow copy of the registers and the running average
   logic                enabled_q;
   logic [GRAV_W-1:0]   gravity_q;
   logic [WEIGHT_W-1:0] weight_q;
   logic [AVG_W-1:0]    average_q;

   // levels predicted at sample acceptance, oldest first
   logic [LEVEL_W-1:0]  level_queue[$];

   int mismatch_total;
   int level_total;

   // magnitude of a signed 17-bit axis reading, 65536 included
   function automatic logic [17:0] axis_size(input logic [AXIS_W-1:0] raw);
      logic [17:0] wide;
      wide = {raw[AXIS_W-1], raw};
      return raw[AXIS_W-1] ? 18'd0 - wide : wide;
   endfunction

   // floor square root, one result bit per trial from the top down
   function automatic logic [MAG_W-1:0] floor_root(input logic [SUM_W-1:0] radicand);
      logic [17:0] root;
      logic [35:0] trial;
      root = '0;
      for (int b = 17; b >= 0; b--) begin
         trial = root | (18'd1 << b);
         if (trial * trial <= 36'(radicand))
            root = trial[17:0];
      end
      return root[MAG_W-1:0];
   endfunction

   // moves the average by one sample and returns the rounded level; zero when disabled
   function automatic logic [LEVEL_W-1:0] advance_level(input logic [AXIS_W-1:0] x,
                                                        input logic [AXIS_W-1:0] y,
                                                        input logic [AXIS_W-1:0] z);
      logic [17:0]      ax, ay, az;
      logic [35:0]      energy;
      logic [MAG_W-1:0] root;
      logic [MAG_W-1:0] excess;
      logic [47:0]      blend;
      logic [25:0]      rounded;
      if (!enabled_q)
         return '0;
      ax = axis_size(x);
      ay = axis_size(y);
      az = axis_size(z);
      energy = 36'(ax) * ax + 36'(ay) * ay + 36'(az) * az;
      root = floor_root(energy[SUM_W-1:0]);
      // distance from gravity, whichever side the magnitude is on
      excess = (root >= MAG_W'(gravity_q)) ? root - MAG_W'(gravity_q)
                                           : MAG_W'(gravity_q) - root;
      blend = 48'(weight_q) * {excess, 8'd0}
            + (48'd65536 - 48'(weight_q)) * 48'(average_q) + 48'd32768;
      average_q = blend[16 +: AVG_W];
      rounded = 26'(average_q) + 26'd32768;
      return rounded[16 +: LEVEL_W];
   endfunction

   task automatic flag_mismatch(input string what, input longint unsigned want,
                                input longint unsigned got);
      mismatch_total++;
      if (mismatch_total <= 10)
         $display("%t checker: %s expected %0d got %0d", $time, what, want, got);
   endtask

   always @(posedge clock) begin
      logic [CSR_DW-1:0]  stored;
      logic               mapped;
      logic [LEVEL_W-1:0] want;
      if (reset) begin
         enabled_q = ENABLE_RESET;
         gravity_q = GRAVITY_RESET;
         weight_q  = WEIGHT_RESET;
         average_q = '0;
         level_queue.delete();
      end else begin
         // register access phase
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (csr_paddr[CSR_AW-1:2])
                  REG_ENABLE:  enabled_q = csr_pwdata[0];
                  REG_GRAVITY: gravity_q = csr_pwdata[GRAV_W-1:0];
                  REG_WEIGHT:  weight_q  = csr_pwdata[WEIGHT_W-1:0];
                  default:     ;
               endcase
            end else begin
               mapped = 1'b1;
               stored = '0;
               case (csr_paddr[CSR_AW-1:2])
                  REG_ENABLE:  stored = CSR_DW'(enabled_q);
                  REG_GRAVITY: stored = CSR_DW'(gravity_q);
                  REG_WEIGHT:  stored = CSR_DW'(weight_q);
                  default:     mapped = 1'b0;
               endcase
               if (mapped && csr_prdata !== stored)
                  flag_mismatch($sformatf("register read at 0x%0h", csr_paddr),
                                stored, csr_prdata);
            end
         end

         // sample transaction
         if (req_mon.valid && req_mon.ready)
            level_queue.push_back(advance_level(req_mon.accel_x, req_mon.accel_y,
                                                req_mon.accel_z));

         // level transaction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (level_queue.size() == 0) begin
               flag_mismatch("level with nothing outstanding", 0, rsp_mon.smoothed_level);
            end else begin
               want = level_queue.pop_front();
               level_total++;
               if (rsp_mon.smoothed_level !== want)
                  flag_mismatch("smoothed_level", want, rsp_mon.smoothed_level);
            end
         end
      end
      pending_levels <= level_queue.size();
      mismatch_count <= mismatch_total;
      levels_checked <= level_total;
   end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
   import adms_pkg::*;

   localparam int              RANDOM_PHASES   = 10;
   localparam int              ENABLED_SAMPLES = 229;
   localparam int              IDLE_SAMPLES    = 60;
   localparam int              WATCHDOG_LIMIT  = 4000;
   localparam int              DRAIN_CYCLES    = 60;
   localparam logic [CSR_AW-1:0] UNUSED_REG_ADDR = 4'hC;

   logic              clock;
   logic              reset;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;
   logic              sink_ready = 1'b0;

   int mismatch_count;
   int pending_levels;
   int levels_checked;
   int samples_sent;
   int settings_applied;
   int burst_left;
   int ready_hold;
   int quiet_cycles;

   adms_req_if req_chan ();
   adms_rsp_if rsp_chan ();

   assign rsp_chan.ready = sink_ready;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   accel_dynamic_magnitude_smoother dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   adms_level_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .pending_levels (pending_levels),
      .levels_checked (levels_checked)
   );

   // receiver: open stretches, long stalls and short random flicker
   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold--;
      end else begin
         case ($urandom_range(0, 3))
            0: begin
               sink_ready <= 1'b1;
               ready_hold = $urandom_range(20, 120);
            end
            1: begin
               sink_ready <= 1'b0;
               ready_hold = $urandom_range(1, 30);
            end
            default: begin
               sink_ready <= 1'($urandom_range(0, 1));
               ready_hold = $urandom_range(0, 3);
            end
         endcase
      end
   end

   // watchdog on cycles with no transaction of any kind
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [CSR_AW-1:0] reg_addr(input reg_index_type idx);
      return {idx, 2'b00};
   endfunction

   // two-phase register access; psel drops before the task returns so accesses never overlap
   task automatic csr_access(input logic write, input logic [CSR_AW-1:0] addr,
                             input logic [CSR_DW-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // writes carry junk in the bits above each register
   task automatic apply_setting(input logic en, input logic [GRAV_W-1:0] grav,
                                input logic [WEIGHT_W-1:0] weight);
      csr_access(1'b1, reg_addr(REG_ENABLE), ($urandom() & ~32'h1) | CSR_DW'(en));
      csr_access(1'b1, reg_addr(REG_GRAVITY), {16'($urandom()), grav});
      csr_access(1'b1, reg_addr(REG_WEIGHT), {16'($urandom()), weight});
      csr_access(1'b0, reg_addr(REG_ENABLE), '0);
      csr_access(1'b0, reg_addr(REG_GRAVITY), '0);
      csr_access(1'b0, reg_addr(REG_WEIGHT), '0);
      settings_applied++;
   endtask

   // bursts of random length, gaps of random length between them
   task automatic send_sample(input logic [AXIS_W-1:0] x, input logic [AXIS_W-1:0] y,
                              input logic [AXIS_W-1:0] z);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
      end
      req_chan.valid   <= 1'b1;
      req_chan.accel_x <= x;
      req_chan.accel_y <= y;
      req_chan.accel_z <= z;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      burst_left--;
      samples_sent++;
   endtask

   // drop valid and wait until every predicted level has come back
   task automatic drain_levels();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_levels != 0)
         @(posedge clock);
   endtask

   // mostly in-range readings, some near gravity, some raw 17-bit patterns
   function automatic logic [AXIS_W-1:0] pick_axis(input int unsigned kind);
      int v;
      if (kind < 50)
         v = int'($urandom_range(0, 81920)) - 40960;
      else if (kind < 75)
         v = int'($urandom_range(0, 6000)) - 3000;
      else if (kind < 90)
         v = int'($urandom());
      else begin
         case ($urandom_range(0, 4))
            0:       v = -65536;
            1:       v = -40960;
            2:       v = 0;
            3:       v = 40960;
            default: v = 65535;
         endcase
      end
      return v[AXIS_W-1:0];
   endfunction

   initial begin
      int               count;
      int unsigned      kind;
      logic             en;
      logic [GRAV_W-1:0]   grav;
      logic [WEIGHT_W-1:0] weight;

      reset            <= 1'b1;
      csr_psel         <= 1'b0;
      csr_penable      <= 1'b0;
      csr_pwrite       <= 1'b0;
      csr_paddr        <= '0;
      csr_pwdata       <= '0;
      req_chan.valid   <= 1'b0;
      req_chan.accel_x <= '0;
      req_chan.accel_y <= '0;
      req_chan.accel_z <= '0;
      burst_left       = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values, then samples while still disabled
      csr_access(1'b0, reg_addr(REG_ENABLE), '0);
      csr_access(1'b0, reg_addr(REG_GRAVITY), '0);
      csr_access(1'b0, reg_addr(REG_WEIGHT), '0);
      send_sample(17'sd40960, 17'sd0, 17'sd0);
      send_sample(-17'sd40960, 17'sd1000, -17'sd5);
      send_sample(17'h10000, 17'h0FFFF, 17'h1FFFF);
      drain_levels();

      // enable only, gravity and weight stay at reset; unmapped write is dropped
      csr_access(1'b1, reg_addr(REG_ENABLE), 32'h1);
      csr_access(1'b1, UNUSED_REG_ADDR, 32'hFFFF_FFFF);
      csr_access(1'b0, reg_addr(REG_ENABLE), '0);
      csr_access(1'b0, reg_addr(REG_GRAVITY), '0);
      csr_access(1'b0, reg_addr(REG_WEIGHT), '0);
      settings_applied++;

      // directed: zero, exact gravity, below gravity, extremes and raw patterns
      send_sample(17'sd0, 17'sd0, 17'sd0);
      send_sample(17'sd2510, 17'sd0, 17'sd0);
      send_sample(17'sd0, 17'sd0, -17'sd2510);
      send_sample(17'sd0, 17'sd2511, 17'sd0);
      send_sample(17'sd1500, -17'sd1500, 17'sd1500);
      send_sample(17'sd1, 17'sd0, 17'sd0);
      send_sample(17'sd40960, 17'sd40960, 17'sd40960);
      send_sample(-17'sd40960, -17'sd40960, -17'sd40960);
      send_sample(17'sd40960, -17'sd40960, 17'sd0);
      send_sample(17'h10000, 17'h10000, 17'h10000);
      send_sample(17'h0FFFF, 17'h0FFFF, 17'h0FFFF);
      send_sample(17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
      send_sample(17'h10000, 17'sd0, 17'sd0);
      send_sample(17'h0AAAA, 17'h15555, 17'h0AAAA);
      send_sample(17'h15555, 17'h0AAAA, 17'h15555);
      send_sample(17'sd0, 17'sd0, 17'sd0);
      drain_levels();

      // random phases, each under its own register setting
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         en     = 1'b1;
         grav   = 16'($urandom());
         weight = 16'($urandom());
         case (phase)
            0: begin grav = GRAVITY_RESET; weight = WEIGHT_RESET; end
            1: begin grav = 16'h0000; weight = 16'hFFFF; end
            2: begin grav = 16'hFFFF; weight = 16'h0000; end
            3: en = 1'b0;
            4: begin grav = GRAVITY_RESET; weight = 16'd1; end
            6: begin grav = 16'd1000; weight = 16'd32768; end
            7: begin en = 1'b0; grav = GRAVITY_RESET; weight = WEIGHT_RESET; end
            9: begin grav = GRAVITY_RESET; weight = 16'hFFFF; end
            default: ;
         endcase
         apply_setting(en, grav, weight);
         if ($urandom_range(0, 2) == 0)
            csr_access(1'b1, UNUSED_REG_ADDR, $urandom());
         count = en ? ENABLED_SAMPLES : IDLE_SAMPLES;
         repeat (count) begin
            kind = $urandom_range(0, 99);
            send_sample(pick_axis(kind), pick_axis(kind), pick_axis(kind));
         end
         drain_levels();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("tb: %0d samples sent, %0d levels compared, %0d register settings",
               samples_sent, levels_checked, settings_applied);
      $display("tb: settings spanned disabled, zero/full weight and zero/full gravity offset");
      if (mismatch_count == 0 && pending_levels == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/adms_pkg.sv
hw/rtl/adms_req_if.sv
hw/rtl/adms_rsp_if.sv
hw/rtl/accel_dynamic_magnitude_smoother.sv
tb/adms_level_checker.sv
tb/tb.sv
